// ===== src/page_frame_bitmap_allocator_top_macros.svh =====
// Assertion macros used by the frame allocator top level.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pfba_pkg.sv =====
// Package with the shared types and constants of the frame allocator.
`timescale 1ns / 1ps
package pfba_pkg;

	localparam int ADDR_W        = 32;
	localparam int FRAME_SHIFT   = 12;
	localparam int FRAME_W       = ADDR_W - FRAME_SHIFT;
	localparam int PAGES_W       = 17;
	localparam int SUM_BITS      = 32;
	localparam int SUM_IW        = 5;
	localparam int NUM_FRAMES_DEF = 65536;
	localparam int WORD_BITS_DEF  = 32;

	localparam logic [ADDR_W-1:0]  ALLOC_FAIL  = 32'hFFFF_FFFF;
	localparam logic [PAGES_W-1:0] PAGES_RESET = 17'h1_0000;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_FREE    = 2'd1,
		ACT_RESERVE = 2'd2,
		ACT_NONE    = 2'd3
	} pfba_action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALOC_TOP,
		ST_ALOC_SUM,
		ST_ALOC_WORD,
		ST_ALOC_FAIL,
		ST_UPD_MUL,
		ST_UPD_DIV,
		ST_UPD_READ,
		ST_UPD_WRITE
	} pfba_state_t;

endpackage

// ===== src/page_frame_bitmap_allocator_top.sv =====
// Top level of the first-fit physical frame allocator.
`timescale 1ns / 1ps
`include "page_frame_bitmap_allocator_top_macros.svh"
// The allocator keeps one used bit per 4 KiB frame in a bitmap RAM and takes one item
// at a time. A word-level summary RAM (one bit per bitmap word that still holds a free
// frame) and a row of flip-flops (one bit per nonzero summary word) steer the search,
// so an allocate item passes through a priority pick over the flip-flops, a summary
// RAM read, a bitmap RAM read, then the write-back with the result loaded into the
// output register, held while the output stalls. When no flip-flop is set the allocate
// item fails after the pick. A free or reserve item takes the word/bit split of the
// frame number (states MUL and DIV), one RAM read and one
// write-back. No clearing pass runs after reset: a cleared summary level marks every
// word below it as fully used, so the block takes items right after reset. Free and
// reserve of a frame beyond the store, and the unused action code, finish at once with
// no result. The result register lets an item be accepted while a result still waits.
module page_frame_bitmap_allocator_top #(
	parameter int NumFrames = pfba_pkg::NUM_FRAMES_DEF,
	parameter int WordBits  = pfba_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pfba_pkg::PAGES_W-1:0] cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [pfba_pkg::ADDR_W-1:0]  frame_address,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pfba_pkg::ADDR_W-1:0]  allocated_address,
	output logic                         no_free_frame
);
	import pfba_pkg::*;

	localparam int Words  = (NumFrames + WordBits - 1) / WordBits;
	localparam int WordAw = (Words > 1) ? $clog2(Words) : 1;
	localparam int Tops   = (Words + SUM_BITS - 1) / SUM_BITS;
	localparam int TopW   = (Tops > 1) ? $clog2(Tops) : 1;
	localparam int WidxW  = TopW + SUM_IW;
	localparam int BitW   = $clog2(WordBits);
	localparam int FrW    = FRAME_W + 1;

	pfba_state_t state_q, state_d;

	logic [PAGES_W-1:0] pages_q;
	logic [Tops-1:0]    top_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_fail_q;

	logic [FRAME_W-1:0]  frame_q;
	logic                set_q;
	logic [TopW-1:0]     t_q;
	logic [SUM_IW-1:0]   s_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [FrW-1:0]      base_q;

	logic                in_accept;
	logic                out_free;
	logic [FRAME_W-1:0]  in_frame;
	logic                in_range;
	logic                top_hit;
	logic [TopW-1:0]     top_sel;
	logic [SUM_IW-1:0]   sum_sel;
	logic [BitW-1:0]     zero_sel;
	logic [WidxW-1:0]    alloc_w;
	logic [FrW-1:0]      f_alloc;
	logic                alloc_ok;

	logic [WordAw-1:0]   upd_word;
	logic [BitW-1:0]     upd_b;
	logic [WidxW-1:0]    upd_widx;
	logic [TopW-1:0]     upd_t;
	logic [SUM_IW-1:0]   upd_s;

	logic [TopW-1:0]     wr_t;
	logic [SUM_IW-1:0]   wr_s;
	logic [WidxW-1:0]    wr_widx;
	logic [BitW-1:0]     wr_b;
	logic                wr_set;
	logic [SUM_BITS-1:0] sum_old;
	logic [SUM_BITS-1:0] sum_new;
	logic [WordBits-1:0] word_old;
	logic [WordBits-1:0] word_new;
	logic [WordBits-1:0] bit_mask;

	logic                sum_rd_en;
	logic [TopW-1:0]     sum_rd_addr;
	logic [SUM_BITS-1:0] sum_rd;
	logic                bm_rd_en;
	logic [WordAw-1:0]   bm_rd_addr;
	logic [WordBits-1:0] bm_rd;
	logic                commit;
	logic                push;
	logic                push_fail;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_frame  = frame_address[ADDR_W-1:FRAME_SHIFT];
	assign in_range  = FrW'(in_frame) < FrW'(NumFrames);

	// Lowest flip-flop marking a summary word with a free word below it.
	always_comb begin
		top_hit = 1'b0;
		top_sel = '0;
		for (int i = Tops - 1; i >= 0; i--) begin
			if (top_q[i]) begin
				top_hit = 1'b1;
				top_sel = TopW'(i);
			end
		end
	end

	always_comb begin
		sum_sel = '0;
		for (int i = SUM_BITS - 1; i >= 0; i--) begin
			if (sum_rd[i]) begin
				sum_sel = SUM_IW'(i);
			end
		end
	end

	always_comb begin
		zero_sel = '0;
		for (int i = WordBits - 1; i >= 0; i--) begin
			if (!bm_rd[i]) begin
				zero_sel = BitW'(i);
			end
		end
	end

	assign alloc_w  = {t_q, sum_sel};
	assign f_alloc  = base_q + FrW'(zero_sel);
	// Frames at or beyond the store are never free, so only the scan limit matters.
	assign alloc_ok = f_alloc < FrW'(pages_q);

	pfba_index #(
		.WordBits(WordBits),
		.WordAw  (WordAw)
	) u_index (
		.clk     (clk),
		.frame   (frame_q),
		.word_idx(upd_word),
		.bit_idx (upd_b)
	);

	assign upd_widx = WidxW'(upd_word);
	assign upd_t    = upd_widx[WidxW-1:SUM_IW];
	assign upd_s    = upd_widx[SUM_IW-1:0];

	// Read-modify-write of one bitmap word and its summary word. A cleared flip-flop
	// means its summary word is all zero, and a cleared summary bit means its bitmap
	// word is all ones, whatever the RAMs hold.
	always_comb begin
		if (state_q == ST_UPD_WRITE) begin
			wr_t     = upd_t;
			wr_s     = upd_s;
			wr_b     = upd_b;
			wr_set   = set_q;
			sum_old  = top_q[upd_t] ? sum_rd : '0;
			word_old = sum_old[upd_s] ? bm_rd : '1;
		end else begin
			wr_t     = t_q;
			wr_s     = s_q;
			wr_b     = zero_sel;
			wr_set   = 1'b1;
			sum_old  = sum_q;
			word_old = bm_rd;
		end
		bit_mask      = WordBits'(1) << wr_b;
		word_new      = wr_set ? (word_old | bit_mask) : (word_old & ~bit_mask);
		sum_new       = sum_old;
		sum_new[wr_s] = (word_new != '1);
	end

	assign wr_widx = {wr_t, wr_s};

	pfba_ram #(
		.Width(SUM_BITS),
		.Depth(Tops)
	) u_sum_ram (
		.clk    (clk),
		.wr_en  (commit),
		.wr_addr(wr_t),
		.wr_data(sum_new),
		.rd_en  (sum_rd_en),
		.rd_addr(sum_rd_addr),
		.rd_data(sum_rd)
	);

	pfba_ram #(
		.Width(WordBits),
		.Depth(Words)
	) u_bitmap_ram (
		.clk    (clk),
		.wr_en  (commit),
		.wr_addr(wr_widx[WordAw-1:0]),
		.wr_data(word_new),
		.rd_en  (bm_rd_en),
		.rd_addr(bm_rd_addr),
		.rd_data(bm_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (action == ACT_ALLOC) begin
						state_d = ST_ALOC_TOP;
					end else if ((action == ACT_FREE || action == ACT_RESERVE) && in_range) begin
						state_d = ST_UPD_MUL;
					end
				end
			end
			ST_ALOC_TOP:  state_d = top_hit ? ST_ALOC_SUM : ST_ALOC_FAIL;
			ST_ALOC_SUM:  state_d = ST_ALOC_WORD;
			ST_ALOC_WORD: state_d = out_free ? ST_IDLE : ST_ALOC_WORD;
			ST_ALOC_FAIL: state_d = out_free ? ST_IDLE : ST_ALOC_FAIL;
			ST_UPD_MUL:   state_d = ST_UPD_DIV;
			ST_UPD_DIV:   state_d = ST_UPD_READ;
			ST_UPD_READ:  state_d = ST_UPD_WRITE;
			ST_UPD_WRITE: state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sum_rd_en   = 1'b0;
		sum_rd_addr = top_sel;
		bm_rd_en    = 1'b0;
		bm_rd_addr  = alloc_w[WordAw-1:0];
		commit      = 1'b0;
		push        = 1'b0;
		push_fail   = 1'b0;
		case (state_q)
			ST_ALOC_TOP: begin
				sum_rd_en = top_hit;
			end
			ST_ALOC_SUM: begin
				bm_rd_en = 1'b1;
			end
			ST_ALOC_WORD: begin
				push      = out_free;
				commit    = out_free && alloc_ok;
				push_fail = !alloc_ok;
			end
			ST_ALOC_FAIL: begin
				push      = out_free;
				push_fail = 1'b1;
			end
			ST_UPD_READ: begin
				sum_rd_en   = 1'b1;
				sum_rd_addr = upd_t;
				bm_rd_en    = 1'b1;
				bm_rd_addr  = upd_widx[WordAw-1:0];
			end
			ST_UPD_WRITE: begin
				commit = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pages_q     <= PAGES_RESET;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				pages_q <= cfg_wr_data;
			end
			if (commit) begin
				top_q[wr_t] <= (sum_new != '0);
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			frame_q <= in_frame;
			set_q   <= (action == ACT_RESERVE);
		end
		if (state_q == ST_ALOC_TOP) begin
			t_q <= top_sel;
		end
		if (state_q == ST_ALOC_SUM) begin
			s_q    <= sum_sel;
			sum_q  <= sum_rd;
			base_q <= FrW'(alloc_w) * FrW'(WordBits);
		end
		if (push) begin
			out_addr_q <= push_fail ? ALLOC_FAIL : {f_alloc[FRAME_W-1:0], {FRAME_SHIFT{1'b0}}};
			out_fail_q <= push_fail;
		end
	end

	assign out_valid         = out_valid_q;
	assign allocated_address = out_addr_q;
	assign no_free_frame     = out_fail_q;

	`PFBA_ASSERT_NOW(a_no_result_overwrite, out_valid_q && out_stall, !push, "result overwritten while stalled")
	`PFBA_ASSERT_NOW(a_summary_coherent, state_q == ST_ALOC_SUM, sum_rd != '0, "marked summary word is empty")
	`PFBA_ASSERT_NOW(a_word_has_free, state_q == ST_ALOC_WORD, bm_rd != '1, "marked bitmap word is full")
	`PFBA_ASSERT_NEXT(a_commit_returns_idle, commit, state_q == ST_IDLE, "write-back did not end the item")

endmodule

// ===== src/pfba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pfba_ram #(
	parameter int Width = 32,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/pfba_index.sv =====
// Splits a frame number into bitmap word index and bit index (divide by word width).
`timescale 1ns / 1ps
module pfba_index #(
	parameter int WordBits = 32,
	parameter int WordAw = 11,
	localparam int BitW = $clog2(WordBits)
) (
	input  logic                        clk,
	input  logic [pfba_pkg::FRAME_W-1:0] frame,
	output logic [WordAw-1:0]           word_idx,
	output logic [BitW-1:0]             bit_idx
);
	import pfba_pkg::*;

	// Reciprocal is low by at most one quotient step, fixed by one compare.
	localparam int Recip = (1 << FRAME_W) / WordBits;
	localparam int ProdW = 2 * FRAME_W + 1;

	logic [ProdW-1:0]   prod_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [FRAME_W-1:0] q0;
	logic [FRAME_W-1:0] r0;
	logic [FRAME_W-1:0] quot;
	logic [FRAME_W-1:0] rem;
	logic [WordAw-1:0]  word_s2;
	logic [BitW-1:0]    bit_s2;

	always_ff @(posedge clk) begin
		prod_s1  <= ProdW'(frame) * ProdW'(Recip);
		frame_s1 <= frame;
		word_s2  <= WordAw'(quot);
		bit_s2   <= rem[BitW-1:0];
	end

	always_comb begin
		q0 = FRAME_W'(prod_s1 >> FRAME_W);
		r0 = frame_s1 - (q0 * FRAME_W'(WordBits));
		if (r0 >= FRAME_W'(WordBits)) begin
			quot = q0 + FRAME_W'(1);
			rem  = r0 - FRAME_W'(WordBits);
		end else begin
			quot = q0;
			rem  = r0;
		end
	end

	assign word_idx = word_s2;
	assign bit_idx  = bit_s2;

endmodule
